// ===== hw/rtl/trilinear_velocity_interpolator_core_defines.svh =====
// Assertion macros used by the checker file tvi_checker.sv.
// No dependencies; each macro expects a clock i_clk and reset i_rst_n in scope.
`ifndef TRILINEAR_VELOCITY_INTERPOLATOR_CORE_DEFINES_SVH
`define TRILINEAR_VELOCITY_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication
`define TVI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// implication after a constant delay
`define TVI_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== hw/rtl/tvi_pkg.sv =====
// Shared constants for the trilinear interpolator.
// No dependencies.
package tvi_pkg;

    localparam int POS_WIDTH    = 24;
    // cycles through one interpolation step (difference, then multiply-add)
    localparam int LERP_LATENCY = 2;
    // three steps: z, y, x
    localparam int PIPE_LATENCY = 3 * LERP_LATENCY;

endpackage

// ===== hw/rtl/tvi_lerp.sv =====
// One linear interpolation step over LANES lanes sharing a weight:
// y = a + floor((b - a) * f / 2^FRAC_BITS). Two register stages. Uses tvi_pkg.
module tvi_lerp import tvi_pkg::*; #(
    parameter int LANES       = 1,
    parameter int FRAC_BITS   = 12,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic        [FRAC_BITS-1:0]   i_f,
    input  logic signed [VALUE_WIDTH-1:0] i_a [LANES],
    input  logic signed [VALUE_WIDTH-1:0] i_b [LANES],
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_y [LANES]
);

    localparam int DIFF_W = VALUE_WIDTH + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic [LERP_LATENCY-1:0]       r_valid;
    logic signed [VALUE_WIDTH-1:0] r_a [LANES];
    logic signed [DIFF_W-1:0]      r_d [LANES];
    logic        [FRAC_BITS-1:0]   r_f;
    logic signed [VALUE_WIDTH-1:0] r_y [LANES];

    logic signed [PROD_W-1:0]      n_prod  [LANES];
    logic signed [PROD_W-1:0]      n_shift [LANES];
    logic signed [VALUE_WIDTH-1:0] n_y     [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[LERP_LATENCY-2:0], i_valid};
        end
    end

    // stage 1: difference b - a, one bit wider than the operands
    always_ff @(posedge i_clk) begin
        r_f <= i_f;
        for (int l = 0; l < LANES; l++) begin
            r_a[l] <= i_a[l];
            r_d[l] <= $signed({i_b[l][VALUE_WIDTH-1], i_b[l]})
                    - $signed({i_a[l][VALUE_WIDTH-1], i_a[l]});
        end
    end

    // stage 2: weight the difference; a*2^F has zero low bits, so the floor
    // shift applies to the product alone. Result is convex, fits VALUE_WIDTH.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_prod[l]  = r_d[l] * $signed({1'b0, r_f});
            n_shift[l] = n_prod[l] >>> FRAC_BITS;
            n_y[l]     = r_a[l] + $signed(n_shift[l][VALUE_WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_y[l] <= n_y[l];
        end
    end

    assign o_valid = r_valid[LERP_LATENCY-1];
    assign o_y     = r_y;

endmodule

// ===== hw/rtl/trilinear_velocity_interpolator_core.sv =====
// Trilinear interpolation of one velocity component from eight corner values.
// Depends on tvi_pkg and tvi_lerp.
//
// Usage:
//   Drive the position and the eight corners and raise start for one cycle;
//   the word is taken at the clock edge where start is high and busy is low.
//   Only the low FRAC_BITS bits of each coordinate are used as weights.
//   Interpolation runs along z (four lanes), then y (two), then x (one),
//   each step two register stages: a subtract, then a multiply-add.
//   Throughput: one word per cycle; busy is low in every cycle after the
//   first one following reset, so words may be issued back to back.
//   The result sits on o_interpolated for the single cycle o_valid is high;
//   the receiver cannot stall, and none is needed as nothing backs up.
//   Reset (synchronous, active low) clears all valid bits, drops words in
//   flight, and holds busy high for one cycle after release.
//   Three components are handled as three independent words.
module trilinear_velocity_interpolator_core import tvi_pkg::*; #(
    parameter int FRAC_BITS   = 12,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic        [POS_WIDTH-1:0]   i_pos_x,
    input  logic        [POS_WIDTH-1:0]   i_pos_y,
    input  logic        [POS_WIDTH-1:0]   i_pos_z,
    input  logic signed [VALUE_WIDTH-1:0] i_v000,
    input  logic signed [VALUE_WIDTH-1:0] i_v001,
    input  logic signed [VALUE_WIDTH-1:0] i_v010,
    input  logic signed [VALUE_WIDTH-1:0] i_v011,
    input  logic signed [VALUE_WIDTH-1:0] i_v100,
    input  logic signed [VALUE_WIDTH-1:0] i_v101,
    input  logic signed [VALUE_WIDTH-1:0] i_v110,
    input  logic signed [VALUE_WIDTH-1:0] i_v111,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_interpolated
);

    logic r_busy;

    logic [FRAC_BITS-1:0] r_fy_dly [LERP_LATENCY];
    logic [FRAC_BITS-1:0] r_fx_dly [2*LERP_LATENCY];

    logic                          accept;
    logic signed [VALUE_WIDTH-1:0] z_a [4];
    logic signed [VALUE_WIDTH-1:0] z_b [4];
    logic signed [VALUE_WIDTH-1:0] z_y [4];
    logic                          z_valid;
    logic signed [VALUE_WIDTH-1:0] y_a [2];
    logic signed [VALUE_WIDTH-1:0] y_b [2];
    logic signed [VALUE_WIDTH-1:0] y_y [2];
    logic                          y_valid;
    logic signed [VALUE_WIDTH-1:0] x_a [1];
    logic signed [VALUE_WIDTH-1:0] x_b [1];
    logic signed [VALUE_WIDTH-1:0] x_y [1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // the y weight follows the data through the z step, the x weight through the z and y steps
    always_ff @(posedge i_clk) begin
        r_fy_dly[0] <= i_pos_y[FRAC_BITS-1:0];
        for (int i = 1; i < LERP_LATENCY; i++) begin
            r_fy_dly[i] <= r_fy_dly[i-1];
        end
        r_fx_dly[0] <= i_pos_x[FRAC_BITS-1:0];
        for (int i = 1; i < 2*LERP_LATENCY; i++) begin
            r_fx_dly[i] <= r_fx_dly[i-1];
        end
    end

    assign z_a[0] = i_v000;
    assign z_b[0] = i_v001;
    assign z_a[1] = i_v010;
    assign z_b[1] = i_v011;
    assign z_a[2] = i_v100;
    assign z_b[2] = i_v101;
    assign z_a[3] = i_v110;
    assign z_b[3] = i_v111;

    tvi_lerp #(
        .LANES       (4),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lerp_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_f     (i_pos_z[FRAC_BITS-1:0]),
        .i_a     (z_a),
        .i_b     (z_b),
        .o_valid (z_valid),
        .o_y     (z_y)
    );

    assign y_a[0] = z_y[0];
    assign y_b[0] = z_y[1];
    assign y_a[1] = z_y[2];
    assign y_b[1] = z_y[3];

    tvi_lerp #(
        .LANES       (2),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lerp_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (z_valid),
        .i_f     (r_fy_dly[LERP_LATENCY-1]),
        .i_a     (y_a),
        .i_b     (y_b),
        .o_valid (y_valid),
        .o_y     (y_y)
    );

    assign x_a[0] = y_y[0];
    assign x_b[0] = y_y[1];

    tvi_lerp #(
        .LANES       (1),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_lerp_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (y_valid),
        .i_f     (r_fx_dly[2*LERP_LATENCY-1]),
        .i_a     (x_a),
        .i_b     (x_b),
        .o_valid (o_valid),
        .o_y     (x_y)
    );

    assign o_interpolated = x_y[0];

endmodule

// ===== hw/rtl/tvi_checker.sv =====
// Port-level checks for the trilinear interpolator, bound to the top level.
// Depends on tvi_pkg and trilinear_velocity_interpolator_core_defines.svh.
`include "trilinear_velocity_interpolator_core_defines.svh"

module tvi_checker import tvi_pkg::*; #(
    parameter int FRAC_BITS   = 12,
    parameter int VALUE_WIDTH = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic        [POS_WIDTH-1:0]   i_pos_x,
    input logic        [POS_WIDTH-1:0]   i_pos_y,
    input logic        [POS_WIDTH-1:0]   i_pos_z,
    input logic signed [VALUE_WIDTH-1:0] i_v000,
    input logic signed [VALUE_WIDTH-1:0] i_v001,
    input logic signed [VALUE_WIDTH-1:0] i_v010,
    input logic signed [VALUE_WIDTH-1:0] i_v011,
    input logic signed [VALUE_WIDTH-1:0] i_v100,
    input logic signed [VALUE_WIDTH-1:0] i_v101,
    input logic signed [VALUE_WIDTH-1:0] i_v110,
    input logic signed [VALUE_WIDTH-1:0] i_v111,
    input logic                          o_valid,
    input logic signed [VALUE_WIDTH-1:0] o_interpolated
);

    logic word_in;
    logic on_lattice;
    logic all_equal;

    assign word_in    = start && !busy;
    assign on_lattice = (i_pos_x[FRAC_BITS-1:0] == '0) && (i_pos_y[FRAC_BITS-1:0] == '0)
                     && (i_pos_z[FRAC_BITS-1:0] == '0);
    // a flat field must come back unchanged whatever the weights
    assign all_equal  = (i_v001 == i_v000) && (i_v010 == i_v000) && (i_v011 == i_v000)
                     && (i_v100 == i_v000) && (i_v101 == i_v000) && (i_v110 == i_v000)
                     && (i_v111 == i_v000);

    `TVI_ASSERT_DELAY(a_word_strobes, word_in, PIPE_LATENCY, o_valid,
        "accepted word gave no strobe")
    `TVI_ASSERT_IMPL(a_strobe_has_word, o_valid, $past(word_in, PIPE_LATENCY),
        "strobe without a word")
    `TVI_ASSERT_DELAY(a_lattice_point, word_in && on_lattice, PIPE_LATENCY,
        o_interpolated == $past(i_v000, PIPE_LATENCY), "lattice point not the lower corner")
    `TVI_ASSERT_DELAY(a_flat_field, word_in && all_equal, PIPE_LATENCY,
        o_interpolated == $past(i_v000, PIPE_LATENCY), "flat field changed")
    `TVI_ASSERT_IMPL(a_busy_idle, busy, !o_valid, "strobe while busy after reset")

endmodule

bind trilinear_velocity_interpolator_core tvi_checker #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tvi_checker (.*);
